[design/tli_pkg.sv]
// shared constants for the table linear interpolation block
`default_nettype none

package tli_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 16;
   localparam int VAL_W       = 16;
   localparam int ENTRY_W     = KEY_W + VAL_W;
   localparam int PROD_W      = KEY_W + VAL_W;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

endpackage : tli_pkg

`default_nettype wire

[design/tli_table_ram.sv]
// single port write, single port read table memory with registered read data
`default_nettype none

module tli_table_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : tli_table_ram

`default_nettype wire

[design/tli_divider.sv]
// radix-2 restoring divider, quotient known to fit the value width
`default_nettype none

module tli_divider
   import tli_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [KEY_W-1:0]  divisor,
   output logic                   done,
   output logic      [VAL_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(VAL_W);

   logic [KEY_W-1:0]  rem_ff,  rem_in;
   logic [VAL_W-1:0]  quo_ff,  quo_in;
   logic [KEY_W-1:0]  dsr_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              active_ff, active_in;
   logic              done_ff,   done_in;
   logic [KEY_W:0]    trial;

   // dividend high half is below the divisor, so one bit per step suffices
   assign trial = {rem_ff, quo_ff[VAL_W-1]};

   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = dividend[PROD_W-1:VAL_W];
         quo_in    = dividend[VAL_W-1:0];
         step_in   = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = KEY_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_in = trial[KEY_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(VAL_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : tli_divider

`default_nettype wire

[design/table_linear_interpolation.sv]
// top level: piecewise linear lookup table with sequential scan and divider
//
//   channel   ports                          handshake
//   -------   ----------------------------   ----------------------------------
//   request   start, busy, req_*             beat taken when start & !busy
//   response  rsp_valid, rsp_*               one-cycle strobe, cannot be held off
//   csr       csr_valid, csr_ready, csr_*    beat taken when csr_valid & csr_ready
//
// a write beat is taken with busy staying low; the entry is in memory
// for the very next beat. a query clamps to the first entry or else to
// the last in-use one, and otherwise scans for its segment, multiplies
// and divides; its cost is set by the linear scan over the table memory
// (one entry per cycle, registered read) and the 16-step divider.
// synchronous reset clears the control state and sets the entry count to 1;
// the table memory itself is not cleared. the receiver cannot stall.
`default_nettype none

module table_linear_interpolation
   import tli_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_action,
   input  wire logic [IDX_W-1:0] req_entry_index,
   input  wire logic [KEY_W-1:0] req_entry_key,
   input  wire logic [VAL_W-1:0] req_entry_value,
   input  wire logic [KEY_W-1:0] req_query_key,
   // response channel
   output logic                  rsp_valid,
   output logic      [VAL_W-1:0] rsp_interpolated_value,
   // configuration channel
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_entries_in_use
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_MUL,
      ST_DIVGO,
      ST_DIVWAIT
   } state_type;

   state_type state_ff, state_in;

   // configuration: last in-use index, precomputed at the write
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;

   // query context
   logic [KEY_W-1:0]  query_ff;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [KEY_W-1:0]  lo_key_ff, lo_key_in;
   logic [VAL_W-1:0]  lo_val_ff, lo_val_in;
   logic [KEY_W-1:0]  hi_key_ff, hi_key_in;
   logic [VAL_W-1:0]  hi_val_ff, hi_val_in;
   logic [PROD_W-1:0] prod_ff;
   logic [KEY_W-1:0]  span_ff;
   logic              neg_ff;

   // registered response
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // memory ports
   logic               accept;
   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_val;

   // datapath
   logic [KEY_W-1:0] span;
   logic [KEY_W-1:0] offset;
   logic [VAL_W-1:0] mag;
   logic             div_start;
   logic             div_done;
   logic [VAL_W-1:0] quotient;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // writes go straight into memory on the accepting edge
   assign wr_en = accept && (req_action == ACT_WRITE)
                  && ({1'b0, req_entry_index} < CNT_W'(TABLE_DEPTH));

   assign rd_key = rd_data[ENTRY_W-1:VAL_W];
   assign rd_val = rd_data[VAL_W-1:0];

   // entry count: zero acts as one, saturate at the table depth
   always_comb begin
      last_idx_in = last_idx_ff;
      if (csr_valid && csr_ready) begin
         if (csr_entries_in_use == '0) begin
            last_idx_in = '0;
         end else if (csr_entries_in_use > CNT_W'(TABLE_DEPTH)) begin
            last_idx_in = IDX_W'(TABLE_DEPTH - 1);
         end else begin
            last_idx_in = IDX_W'(csr_entries_in_use - CNT_W'(1));
         end
      end
   end

   // read address for the entry examined in the following cycle
   always_comb begin
      case (state_ff)
         ST_FIRST: rd_addr = last_idx_ff;
         ST_LAST:  rd_addr = IDX_W'(1);
         ST_SCAN:  rd_addr = scan_idx_ff + IDX_W'(1);
         default:  rd_addr = '0;
      endcase
   end

   // segment geometry, valid in ST_MUL
   assign span   = hi_key_ff - lo_key_ff;
   assign offset = query_ff - lo_key_ff;
   assign mag    = (hi_val_ff >= lo_val_ff) ? (hi_val_ff - lo_val_ff)
                                            : (lo_val_ff - hi_val_ff);

   assign div_start = (state_ff == ST_DIVGO);

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      lo_key_in    = lo_key_ff;
      lo_val_in    = lo_val_ff;
      hi_key_in    = hi_key_ff;
      hi_val_in    = hi_val_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_QUERY)) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            // clamp at or below the first key
            if (query_ff <= rd_key) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_val;
               state_in     = ST_IDLE;
            end else begin
               lo_key_in = rd_key;
               lo_val_in = rd_val;
               state_in  = ST_LAST;
            end
         end
         ST_LAST: begin
            // clamp at or above the last in-use key
            if (query_ff >= rd_key) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_val;
               state_in     = ST_IDLE;
            end else begin
               scan_idx_in = IDX_W'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // first key at or above the query closes the segment
            if (query_ff <= rd_key) begin
               hi_key_in = rd_key;
               hi_val_in = rd_val;
               state_in  = ST_MUL;
            end else begin
               lo_key_in   = rd_key;
               lo_val_in   = rd_val;
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_MUL: begin
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = neg_ff ? (lo_val_ff - quotient) : (lo_val_ff + quotient);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_idx_ff  <= last_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      lo_key_ff    <= lo_key_in;
      lo_val_ff    <= lo_val_in;
      hi_key_ff    <= hi_key_in;
      hi_val_ff    <= hi_val_in;
      rsp_value_ff <= rsp_value_in;
      if (accept) begin
         query_ff <= req_query_key;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(offset * mag);
         span_ff <= span;
         neg_ff  <= (hi_val_ff < lo_val_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_value_ff;

   tli_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data ({req_entry_key, req_entry_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule : table_linear_interpolation

`default_nettype wire

[design/tli_checker.sv]
// port-level checker for the table linear interpolation block, with its bind
`default_nettype none

module tli_checker
   import tli_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             req_action,
   input wire logic             rsp_valid
);

   // an accepted query makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_QUERY) |=> busy)
      else $error("query beat did not raise busy");

   // a write finishes in its own cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_WRITE) |=> !busy)
      else $error("write beat left the block busy");

   // a result appears only as the block returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe without a finishing query");

   // one strobe per query, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // reset leaves the block idle and quiet
   assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule : tli_checker

bind table_linear_interpolation tli_checker u_tli_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .rsp_valid  (rsp_valid)
);

`default_nettype wire
